>>> hdl/shcpo_pkg.sv
// Shared types and constants for the shaded circle pixel overlay.
`timescale 1ns / 1ps

package shcpo_pkg;

    // Default coordinate width of the pixel stream.
    localparam int COORD_BITS_DEF = 12;

    // Configuration register widths.
    localparam int CX_BITS  = 14;
    localparam int R_BITS   = 11;
    localparam int LIM_BITS = 2 * (R_BITS + 1);

    // APB address width and register indexes.
    localparam int ADDR_BITS = 4;
    localparam int IDX_BITS  = ADDR_BITS - 2;
    localparam logic [IDX_BITS-1:0] REG_CENTER_X    = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_CENTER_Y    = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_BALL_RADIUS = 2'd2;

    // Highlight square root: a root of up to 127 covers every visible shade.
    localparam int ROOT_BITS = 7;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS  = ROOT_BITS + 3;

    localparam logic [7:0] COLOR_MAX = 8'hFF;

    typedef struct packed {
        logic [CX_BITS-1:0]  cx;
        logic [CX_BITS-1:0]  cy;
        logic [R_BITS-1:0]   r;
        logic [LIM_BITS-1:0] lim;   // (r + 1) squared
    } cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    // Word handed from one square root cell to the next.
    typedef struct packed {
        logic [RAD_BITS-1:0]  rad;
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
        color_t               color;
        logic                 in_ball;
        logic                 near;
    } word_t;

endpackage

>>> hdl/shcpo_regs.sv
// APB configuration registers for the shaded circle pixel overlay.
`timescale 1ns / 1ps

module shcpo_regs
    import shcpo_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output cfg_t                 cfg
);

    logic [CX_BITS-1:0]  cx_reg;
    logic [CX_BITS-1:0]  cy_reg;
    logic [R_BITS-1:0]   r_reg;
    logic [LIM_BITS-1:0] lim_reg;
    logic [LIM_BITS-1:0] lim_next;
    logic [R_BITS:0]     r_plus;
    logic [IDX_BITS-1:0] idx;
    logic                wr_en;

    assign idx   = paddr[ADDR_BITS-1:2];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            r_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_CENTER_X:    cx_reg <= pwdata[CX_BITS-1:0];
                REG_CENTER_Y:    cy_reg <= pwdata[CX_BITS-1:0];
                REG_BALL_RADIUS: r_reg  <= pwdata[R_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // The inside test compares the squared distance against (r + 1) squared.
    assign r_plus   = {1'b0, r_reg} + {{R_BITS{1'b0}}, 1'b1};
    assign lim_next = r_plus * r_plus;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= {{(LIM_BITS-1){1'b0}}, 1'b1};
        end
        else
        begin
            lim_reg <= lim_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CENTER_X:    prdata = {{(32-CX_BITS){1'b0}}, cx_reg};
            REG_CENTER_Y:    prdata = {{(32-CX_BITS){1'b0}}, cy_reg};
            REG_BALL_RADIUS: prdata = {{(32-R_BITS){1'b0}}, r_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg = '{cx: cx_reg, cy: cy_reg, r: r_reg, lim: lim_reg};

endmodule

>>> hdl/shcpo_front.sv
// Offset, squaring and ball test stages ahead of the square root chain.
`timescale 1ns / 1ps

module shcpo_front
    import shcpo_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    input  color_t                in_color,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output word_t                 dn_word
);

    localparam int MAGW  = ((COORD_BITS > 13) ? COORD_BITS : 13) + 2;
    localparam int DW    = MAGW + 1;
    localparam int HW    = MAGW + 2;
    localparam int SQDW  = 2 * MAGW;
    localparam int SQHW  = 2 * (MAGW + 1);

    // Stage 1: offsets to the center and to the doubled highlight spot.
    logic [DW-1:0] dx, dy, dx_abs, dy_abs;
    logic [HW-1:0] hx, hy, hx_abs, hy_abs;
    logic [DW-1:0] cx_d, cy_d;
    logic [HW-1:0] cx_h, cy_h, r_h;

    always_comb
    begin
        cx_d = {{(DW-CX_BITS){cfg.cx[CX_BITS-1]}}, cfg.cx};
        cy_d = {{(DW-CX_BITS){cfg.cy[CX_BITS-1]}}, cfg.cy};
        cx_h = {{(HW-CX_BITS-1){cfg.cx[CX_BITS-1]}}, cfg.cx, 1'b0};
        cy_h = {{(HW-CX_BITS-1){cfg.cy[CX_BITS-1]}}, cfg.cy, 1'b0};
        r_h  = {{(HW-R_BITS){1'b0}}, cfg.r};
        dx = {{(DW-COORD_BITS){1'b0}}, pixel_x} - cx_d;
        dy = {{(DW-COORD_BITS){1'b0}}, pixel_y} - cy_d;
        hx = {{(HW-COORD_BITS-1){1'b0}}, pixel_x, 1'b0} - cx_h - r_h;
        hy = {{(HW-COORD_BITS-1){1'b0}}, pixel_y, 1'b0} - cy_h + r_h;
        dx_abs = dx[DW-1] ? (~dx + 1'b1) : dx;
        dy_abs = dy[DW-1] ? (~dy + 1'b1) : dy;
        hx_abs = hx[HW-1] ? (~hx + 1'b1) : hx;
        hy_abs = hy[HW-1] ? (~hy + 1'b1) : hy;
    end

    logic            s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic            s1_en, s2_en, s3_en;
    logic [MAGW-1:0] s1_dx_reg, s1_dy_reg;
    logic [MAGW:0]   s1_hx_reg, s1_hy_reg;
    color_t          s1_color_reg;
    logic [SQDW-1:0] s2_dx_reg, s2_dy_reg;
    logic [SQHW-1:0] s2_hx_reg, s2_hy_reg;
    color_t          s2_color_reg;
    logic [SQDW:0]   dist_sum;
    logic [SQHW:0]   hl_sum;
    word_t           s3_word_reg;
    word_t           s3_word_next;

    assign s3_en    = !s3_valid_reg || dn_ready;
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_en)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_dx_reg    <= dx_abs[MAGW-1:0];
            s1_dy_reg    <= dy_abs[MAGW-1:0];
            s1_hx_reg    <= hx_abs[MAGW:0];
            s1_hy_reg    <= hy_abs[MAGW:0];
            s1_color_reg <= in_color;
        end
        if (s2_en)
        begin
            s2_dx_reg    <= s1_dx_reg * s1_dx_reg;
            s2_dy_reg    <= s1_dy_reg * s1_dy_reg;
            s2_hx_reg    <= s1_hx_reg * s1_hx_reg;
            s2_hy_reg    <= s1_hy_reg * s1_hy_reg;
            s2_color_reg <= s1_color_reg;
        end
        if (s3_en)
        begin
            s3_word_reg <= s3_word_next;
        end
    end

    // Stage 3: ball test and seed for the highlight square root.
    // The shade is nonzero only while the doubled distance stays below 128,
    // so only a radicand below 2^14 needs its root.
    always_comb
    begin
        dist_sum = {1'b0, s2_dx_reg} + {1'b0, s2_dy_reg};
        hl_sum   = {1'b0, s2_hx_reg} + {1'b0, s2_hy_reg};
        s3_word_next.rad     = hl_sum[RAD_BITS-1:0];
        s3_word_next.rem     = '0;
        s3_word_next.root    = '0;
        s3_word_next.color   = s2_color_reg;
        s3_word_next.in_ball = dist_sum < {{(SQDW+1-LIM_BITS){1'b0}}, cfg.lim};
        s3_word_next.near    = (hl_sum[SQHW:RAD_BITS] == '0);
    end

    assign dn_valid = s3_valid_reg;
    assign dn_word  = s3_word_reg;

endmodule

>>> hdl/shcpo_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per pass.
`timescale 1ns / 1ps

module shcpo_sqrt_cell
    import shcpo_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    output logic  up_ready,
    input  word_t up_word,
    output logic  dn_valid,
    input  logic  dn_ready,
    output word_t dn_word
);

    logic                valid_reg;
    word_t               word_reg;
    word_t               word_next;
    logic [REM_BITS-1:0] rem_sh;
    logic [REM_BITS-1:0] trial;

    // Bring down the next two radicand bits and try the digit one.
    always_comb
    begin
        rem_sh = {up_word.rem[REM_BITS-3:0], up_word.rad[RAD_BITS-1 -: 2]};
        trial  = {{(REM_BITS-ROOT_BITS-2){1'b0}}, up_word.root, 2'b01};
        word_next     = up_word;
        word_next.rad = {up_word.rad[RAD_BITS-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            word_next.rem  = rem_sh - trial;
            word_next.root = {up_word.root[ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            word_next.rem  = rem_sh;
            word_next.root = {up_word.root[ROOT_BITS-2:0], 1'b0};
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

>>> hdl/shaded_circle_pixel_overlay.sv
// Top level of the shaded circle pixel overlay.
`timescale 1ns / 1ps

// Paints a shaded ball over a pixel stream.
//
// Input words carry pixel_x, pixel_y and a background color on an
// in_valid / in_ready handshake; result words carry the output color and
// inside_ball on out_valid / out_ready. A pixel whose floored distance to
// the configured center is at most ball_radius becomes red 255 with green
// and blue set to 255 - 4*h (zero where 4*h would pass 255), where h is the
// floored distance to the highlight spot up and to the right of the center;
// other pixels pass through unchanged.
//
// The datapath is a pipeline of 11 register stages: offsets, squares, the
// ball test, a chain of 7 square root cells (one root bit per cell) and
// the output register. One word is accepted every cycle while the receiver
// keeps taking results, since each stage takes a new word as its previous
// word moves on.
//
// Each stage holds its word while the next one is full, so when the
// receiver stalls, the empty stages behind the output still fill up and
// in_ready drops only once every stage holds a word. Reset empties the
// pipeline and clears the center and radius to zero. The APB port at
// addresses 0, 4 and 8 holds center_x, center_y and ball_radius; write it
// only while no word is in flight.
module shaded_circle_pixel_overlay
    import shcpo_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    input  logic [7:0]            in_red,
    input  logic [7:0]            in_green,
    input  logic [7:0]            in_blue,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_red,
    output logic [7:0]            out_green,
    output logic [7:0]            out_blue,
    output logic                  inside_ball
);

    cfg_t cfg;

    assign pready = 1'b1;

    shcpo_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Slot 0 is the front end output; slot k + 1 is the output of cell k.
    logic  chain_valid [0:ROOT_BITS];
    logic  chain_ready [0:ROOT_BITS];
    word_t chain_word  [0:ROOT_BITS];

    shcpo_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .in_color ('{red: in_red, green: in_green, blue: in_blue}),
        .dn_valid (chain_valid[0]),
        .dn_ready (chain_ready[0]),
        .dn_word  (chain_word[0])
    );

    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_cell
        shcpo_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[k]),
            .up_ready (chain_ready[k]),
            .up_word  (chain_word[k]),
            .dn_valid (chain_valid[k+1]),
            .dn_ready (chain_ready[k+1]),
            .dn_word  (chain_word[k+1])
        );
    end

    // Output register. The root is twice the highlight distance, so
    // 4*h is the root with its lowest bit cleared and shifted left by one.
    word_t      last_word;
    logic       out_en;
    logic       out_valid_reg;
    logic [7:0] shade;
    color_t     out_color_reg;
    color_t     out_color_next;
    logic       inside_reg;

    assign last_word = chain_word[ROOT_BITS];
    assign out_en    = !out_valid_reg || out_ready;
    assign chain_ready[ROOT_BITS] = out_en;

    always_comb
    begin
        shade = last_word.near ?
                (COLOR_MAX - {last_word.root[ROOT_BITS-1:1], 2'b00}) : 8'd0;
        if (last_word.in_ball)
        begin
            out_color_next = '{red: COLOR_MAX, green: shade, blue: shade};
        end
        else
        begin
            out_color_next = last_word.color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= chain_valid[ROOT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            out_color_reg <= out_color_next;
            inside_reg    <= last_word.in_ball;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_red     = out_color_reg.red;
    assign out_green   = out_color_reg.green;
    assign out_blue    = out_color_reg.blue;
    assign inside_ball = inside_reg;

    // A painted pixel is always full red.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_ball |-> out_red == COLOR_MAX)
        else $error("painted pixel without full red");

    // Inside the ball green and blue match and are either zero or 255 - 4*h.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_ball |->
            out_green == out_blue && (out_green == 8'd0 || out_green[1:0] == 2'b11))
        else $error("highlight shade malformed");

    // The input side stalls only when the output holds a word the receiver refuses.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg && !out_ready)
        else $error("input stalled with room in the pipeline");

endmodule
